@@ rtl/cpm_pkg.sv @@
package cpm_pkg;

  // Matrix dimension and seed count of the coupled recurrence
  localparam int unsigned DIM        = 6;
  localparam int unsigned SEED_COUNT = 2;
  // Rows in the matrix store: three rotating banks plus the seed bank
  localparam int unsigned BANKS      = 4;
  localparam int unsigned ROWS       = BANKS * DIM;
  localparam int unsigned ADDR_W     = $clog2(ROWS);
  localparam int unsigned ROW_W      = $clog2(DIM);
  localparam int unsigned INIT_ROWS  = 3 * DIM;
  localparam int unsigned INIT_W     = $clog2(INIT_ROWS);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_F_COEFFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_G_COEFFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_F_SEEDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_G_SEEDS  = 3'd4;

  // Fixed bank holding the seed column
  localparam logic [1:0] SEED_BANK = 2'd3;

  // Cell operations
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR_ALL,
    CELL_CLEAR_R,
    CELL_STEP,
    CELL_ACC
  } cell_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_C,
    ST_RED_S,
    ST_INIT,
    ST_MUL,
    ST_OUT
  } cpm_state_t;

  // Kind of matrix product in flight
  typedef enum logic [1:0] {
    MK_QP,
    MK_PP,
    MK_FIN
  } mul_kind_t;

endpackage

@@ rtl/cpm_ifs.sv @@
interface cpm_query_if #(parameter int unsigned INDEX_WIDTH = 31);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] query_index;
  modport src (output valid, output query_index, input ready);
  modport snk (input valid, input query_index, output ready);
endinterface

interface cpm_result_if #(parameter int unsigned VALUE_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] f_value;
  logic [VALUE_WIDTH-1:0] g_value;
  modport src (output valid, output f_value, output g_value, input ready);
  modport snk (input valid, input f_value, input g_value, output ready);
endinterface

interface cpm_cfg_if #(parameter int unsigned VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [cpm_pkg::CFG_IDX_W-1:0] index;
  logic [3*VALUE_WIDTH-1:0]      data;
  modport src (output valid, output index, output data, input ready);
  modport snk (input valid, input index, input data, output ready);
endinterface

@@ rtl/coupled_recurrence_matrix_power_mod.sv @@
// Coupled recurrence evaluator mod m. Each query beat n returns f(n) and g(n)
// mod m. A row of six modular multiply cells computes one row of a 6x6 matrix
// product, one bit of the left operand per cycle. A query first reduces the
// coefficients and seeds; n below 3 then returns at once. Otherwise the 18
// initial rows of the matrices are loaded, then P+1 products run, where P is
// the bit length plus the popcount of n-2, minus one: up to about 61 products
// for the largest index. One query is worked at a time; the next is taken
// once the result sits in the output register.
module coupled_recurrence_matrix_power_mod #(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  cpm_query_if.snk  in_chan,
  cpm_result_if.src out_chan,
  cpm_cfg_if.snk    cfg_chan
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned D   = cpm_pkg::DIM;
  localparam int unsigned RW  = (3 * W > 64) ? 64 : 3 * W;
  localparam int unsigned SW  = $clog2(W + 3);
  localparam int unsigned BW  = $clog2(W);
  localparam int unsigned AW  = cpm_pkg::ADDR_W;
  localparam int unsigned RWI = cpm_pkg::ROW_W;
  localparam int unsigned IW  = cpm_pkg::INIT_W;

  typedef logic [D-1:0][W-1:0] row_t;

  // Configuration registers
  logic [W-1:0]  modulus_r;
  logic [RW-1:0] f_coeffs_r, g_coeffs_r, f_seeds_r, g_seeds_r;

  // Control and payload registers
  cpm_pkg::cpm_state_t state_r, state_nxt;
  cpm_pkg::mul_kind_t  kind_r, kind_nxt;
  logic [INDEX_WIDTH-1:0] n_r, n_nxt, e_r, e_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [RWI-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [IW-1:0]  w_r, w_nxt;
  logic [1:0]     pb_r, pb_nxt, qb_r, qb_nxt, fb_r, fb_nxt;
  row_t           coef_r, coef_nxt, seed_r, seed_nxt;
  logic [W-1:0]   f_res_r, f_res_nxt, g_res_r, g_res_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   out_f_r, out_f_nxt, out_g_r, out_g_nxt;

  // Matrix store, registered reads
  row_t         mem [cpm_pkg::ROWS];
  row_t         rd_a_r, rd_b_r;
  logic         mem_we;
  logic [AW-1:0] mem_waddr, ra, rb;
  row_t         mem_wdata;

  // Cell row
  cpm_pkg::cell_op_t cell_op;
  logic [D-1:0] a_bits;
  row_t         b_row, accs;

  logic [W-1:0] m_eff, one;
  logic [3*W-1:0] fc_ext, gc_ext, fs_ext, gs_ext;
  row_t         coef_raw, seed_raw, init_row;
  logic [SW-1:0] lim, bidx_full;
  logic [BW-1:0] bidx;
  logic [1:0]   abank, bbank;
  logic         is_red;

  function automatic logic [AW-1:0] row_addr(logic [1:0] bank, logic [RWI-1:0] row);
    return AW'({bank, 2'b00}) + AW'({bank, 1'b0}) + AW'(row);
  endfunction

  assign m_eff = (modulus_r == '0) ? W'(1) : modulus_r;
  assign one   = (m_eff == W'(1)) ? '0 : W'(1);

  // Packed fields, zero beyond what the register holds
  always_comb begin
    fc_ext = (3*W)'(f_coeffs_r);
    gc_ext = (3*W)'(g_coeffs_r);
    fs_ext = (3*W)'(f_seeds_r);
    gs_ext = (3*W)'(g_seeds_r);
    for (int j = 0; j < 3; j++) begin
      coef_raw[j]   = fc_ext[j*W +: W];
      coef_raw[j+3] = gc_ext[j*W +: W];
      seed_raw[j]   = fs_ext[j*W +: W];
      seed_raw[j+3] = gs_ext[j*W +: W];
    end
  end

  // Configuration writes
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(1);
      f_coeffs_r <= '0;
      g_coeffs_r <= '0;
      f_seeds_r  <= '0;
      g_seeds_r  <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        cpm_pkg::REG_MODULUS:  modulus_r  <= cfg_chan.data[W-1:0];
        cpm_pkg::REG_F_COEFFS: f_coeffs_r <= cfg_chan.data[RW-1:0];
        cpm_pkg::REG_G_COEFFS: g_coeffs_r <= cfg_chan.data[RW-1:0];
        cpm_pkg::REG_F_SEEDS:  f_seeds_r  <= cfg_chan.data[RW-1:0];
        cpm_pkg::REG_G_SEEDS:  g_seeds_r  <= cfg_chan.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Initial rows: base matrix, identity, seed column
  always_comb begin
    init_row = '0;
    case (w_r) inside
      IW'(0): begin
        init_row[0] = coef_r[0];
        init_row[1] = coef_r[1];
        init_row[5] = coef_r[2];
      end
      IW'(1): init_row[0] = one;
      IW'(2): init_row[1] = one;
      IW'(3): begin
        init_row[3] = coef_r[3];
        init_row[4] = coef_r[4];
        init_row[2] = coef_r[5];
      end
      IW'(4): init_row[3] = one;
      IW'(5): init_row[4] = one;
      [IW'(6):IW'(11)]: init_row[RWI'(w_r - IW'(6))] = one;
      IW'(12): init_row[0] = seed_r[2];
      IW'(13): init_row[0] = seed_r[1];
      IW'(14): init_row[0] = seed_r[0];
      IW'(15): init_row[0] = seed_r[5];
      IW'(16): init_row[0] = seed_r[4];
      IW'(17): init_row[0] = seed_r[3];
      default: init_row = '0;
    endcase
  end

  // Operand banks for the product in flight
  always_comb begin
    case (kind_r)
      cpm_pkg::MK_QP:  begin abank = qb_r; bbank = pb_r; end
      cpm_pkg::MK_PP:  begin abank = pb_r; bbank = pb_r; end
      default:         begin abank = qb_r; bbank = cpm_pkg::SEED_BANK; end
    endcase
  end
  assign ra = row_addr(abank, i_r);
  assign rb = row_addr(bbank, k_r);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // Cell row control: clear, W multiply steps, accumulate, then write-back
  assign is_red    = (state_r == cpm_pkg::ST_RED_C) || (state_r == cpm_pkg::ST_RED_S);
  assign lim       = (is_red || k_r == RWI'(D - 1)) ? SW'(W + 2) : SW'(W + 1);
  assign bidx_full = SW'(W) - s_r;
  assign bidx      = bidx_full[BW-1:0];

  always_comb begin
    if (s_r == '0)
      cell_op = (is_red || k_r == '0) ? cpm_pkg::CELL_CLEAR_ALL : cpm_pkg::CELL_CLEAR_R;
    else if (s_r <= SW'(W))
      cell_op = cpm_pkg::CELL_STEP;
    else if (s_r == SW'(W + 1))
      cell_op = cpm_pkg::CELL_ACC;
    else
      cell_op = cpm_pkg::CELL_HOLD;
    if (!(is_red || state_r == cpm_pkg::ST_MUL)) cell_op = cpm_pkg::CELL_HOLD;
    for (int j = 0; j < D; j++) begin
      case (state_r)
        cpm_pkg::ST_RED_C: a_bits[j] = coef_raw[j][bidx];
        cpm_pkg::ST_RED_S: a_bits[j] = seed_raw[j][bidx];
        default:           a_bits[j] = rd_a_r[k_r][bidx];
      endcase
      b_row[j] = (state_r == cpm_pkg::ST_MUL) ? rd_b_r[j] : one;
    end
  end

  for (genvar j = 0; j < D; j++) begin : g_cell
    cpm_cell #(.VALUE_WIDTH(W)) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .a_bit   (a_bits[j]),
      .b       (b_row[j]),
      .m       (m_eff),
      .acc_out (accs[j])
    );
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      s_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      w_r         <= '0;
      kind_r      <= cpm_pkg::MK_QP;
      pb_r        <= 2'd0;
      qb_r        <= 2'd1;
      fb_r        <= 2'd2;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      w_r         <= w_nxt;
      kind_r      <= kind_nxt;
      pb_r        <= pb_nxt;
      qb_r        <= qb_nxt;
      fb_r        <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    e_r     <= e_nxt;
    coef_r  <= coef_nxt;
    seed_r  <= seed_nxt;
    f_res_r <= f_res_nxt;
    g_res_r <= g_res_nxt;
    out_f_r <= out_f_nxt;
    out_g_r <= out_g_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    pb_nxt        = pb_r;
    qb_nxt        = qb_r;
    fb_nxt        = fb_r;
    coef_nxt      = coef_r;
    seed_nxt      = seed_r;
    f_res_nxt     = f_res_r;
    g_res_nxt     = g_res_r;
    out_f_nxt     = out_f_r;
    out_g_nxt     = out_g_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mem_we        = 1'b0;
    mem_waddr     = row_addr(fb_r, i_r);
    mem_wdata     = accs;

    case (state_r)
      cpm_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          n_nxt     = in_chan.query_index;
          s_nxt     = '0;
          state_nxt = cpm_pkg::ST_RED_C;
        end
      end
      cpm_pkg::ST_RED_C, cpm_pkg::ST_RED_S: begin
        s_nxt = s_r + SW'(1);
        if (s_r == lim) begin
          s_nxt = '0;
          if (state_r == cpm_pkg::ST_RED_C) begin
            coef_nxt  = accs;
            state_nxt = cpm_pkg::ST_RED_S;
          end else begin
            seed_nxt = accs;
            e_nxt    = n_r - INDEX_WIDTH'(cpm_pkg::SEED_COUNT);
            if (n_r <= INDEX_WIDTH'(cpm_pkg::SEED_COUNT)) begin
              f_res_nxt = accs[RWI'(n_r[1:0])];
              g_res_nxt = accs[RWI'(n_r[1:0]) + RWI'(3)];
              state_nxt = cpm_pkg::ST_OUT;
            end else begin
              w_nxt     = '0;
              pb_nxt    = 2'd0;
              qb_nxt    = 2'd1;
              fb_nxt    = 2'd2;
              state_nxt = cpm_pkg::ST_INIT;
            end
          end
        end
      end
      cpm_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = (w_r < IW'(2 * D)) ? AW'(w_r) : AW'(w_r) + AW'(D);
        mem_wdata = init_row;
        w_nxt     = w_r + IW'(1);
        if (w_r == IW'(cpm_pkg::INIT_ROWS - 1)) begin
          i_nxt     = '0;
          k_nxt     = '0;
          s_nxt     = '0;
          state_nxt = cpm_pkg::ST_MUL;
          if (e_r[0]) begin
            kind_nxt = cpm_pkg::MK_QP;
          end else begin
            kind_nxt = cpm_pkg::MK_PP;
            e_nxt    = e_r >> 1;
          end
        end
      end
      cpm_pkg::ST_MUL: begin
        s_nxt = s_r + SW'(1);
        if (s_r == SW'(W + 2)) begin
          // Row write-back, or capture of the final f and g values
          mem_we = (kind_r != cpm_pkg::MK_FIN);
          if (i_r == RWI'(0)) f_res_nxt = accs[0];
          if (i_r == RWI'(3)) g_res_nxt = accs[0];
        end
        if (s_r == lim) begin
          s_nxt = '0;
          if (k_r != RWI'(D - 1)) begin
            k_nxt = k_r + RWI'(1);
          end else begin
            k_nxt = '0;
            if (i_r != RWI'(D - 1)) begin
              i_nxt = i_r + RWI'(1);
            end else begin
              i_nxt = '0;
              case (kind_r)
                cpm_pkg::MK_QP: begin
                  qb_nxt = fb_r;
                  fb_nxt = qb_r;
                  e_nxt  = e_r >> 1;
                  kind_nxt = ((e_r >> 1) != '0) ? cpm_pkg::MK_PP : cpm_pkg::MK_FIN;
                end
                cpm_pkg::MK_PP: begin
                  pb_nxt = fb_r;
                  fb_nxt = pb_r;
                  if (e_r[0]) begin
                    kind_nxt = cpm_pkg::MK_QP;
                  end else begin
                    kind_nxt = cpm_pkg::MK_PP;
                    e_nxt    = e_r >> 1;
                  end
                end
                default: state_nxt = cpm_pkg::ST_OUT;
              endcase
            end
          end
        end
      end
      cpm_pkg::ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_f_nxt     = f_res_r;
          out_g_nxt     = g_res_r;
          state_nxt     = cpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpm_pkg::ST_IDLE;
    endcase
  end

  assign in_chan.ready    = (state_r == cpm_pkg::ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.f_value = out_f_r;
  assign out_chan.g_value = out_g_r;

endmodule

@@ rtl/cpm_cell.sv @@
module cpm_cell #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  cpm_pkg::cell_op_t      op,
  input  logic                   a_bit,
  input  logic [VALUE_WIDTH-1:0] b,
  input  logic [VALUE_WIDTH-1:0] m,
  output logic [VALUE_WIDTH-1:0] acc_out
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [W-1:0] r_r, r_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W:0]   dbl, dbl_red, add, add_red, sum, sum_red;

  // One interleaved multiply step: r = (2r + bit*b) mod m
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    add     = dbl_red + (a_bit ? {1'b0, b} : '0);
    add_red = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
    sum     = {1'b0, acc_r} + {1'b0, r_r};
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
  end

  // Operation select; a hold cycle keeps both registers
  always_comb begin
    r_nxt   = r_r;
    acc_nxt = acc_r;
    case (op)
      cpm_pkg::CELL_CLEAR_ALL: begin
        r_nxt   = '0;
        acc_nxt = '0;
      end
      cpm_pkg::CELL_CLEAR_R: r_nxt = '0;
      cpm_pkg::CELL_STEP:    r_nxt = add_red[W-1:0];
      cpm_pkg::CELL_ACC:     acc_nxt = sum_red[W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule

@@ rtl/cpm_checker.sv @@
module cpm_checker #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] f_value,
  input logic [VALUE_WIDTH-1:0] g_value
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(f_value) && $stable(g_value))
    else $error("result beat changed while stalled");

  // One query at a time: no beat taken right after another
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("query taken while busy");

  // Reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // A new result appears only after the block was busy
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a query");

endmodule

bind coupled_recurrence_matrix_power_mod cpm_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .f_value   (out_chan.f_value),
  .g_value   (out_chan.g_value)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VW = 16;
  localparam int unsigned IW = 31;
  localparam longint unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [cpm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = cpm_pkg::REG_G_SEEDS + 1'b1;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 75;

  typedef longint unsigned mat_t [cpm_pkg::DIM*cpm_pkg::DIM];

  typedef struct {
    logic [VW-1:0] f;
    logic [VW-1:0] g;
  } fg_pair_t;

  typedef struct {
    int unsigned   setting;
    logic [IW-1:0] n;
    bit            typed;
    logic [VW-1:0] f;
    logic [VW-1:0] g;
  } query_row_t;

  typedef struct {
    logic [VW-1:0]   m;
    logic [3*VW-1:0] fc;
    logic [3*VW-1:0] gc;
    logic [3*VW-1:0] fs;
    logic [3*VW-1:0] gs;
  } cfg_set_t;

  logic clk = 1'b0;
  logic rst_n;
  longint unsigned cycles = 0;
  int unsigned errors = 0;
  bit no_idle = 1'b0;

  // shadow copy of the register file
  logic [VW-1:0]   sh_mod;
  logic [3*VW-1:0] sh_fco, sh_gco, sh_fsd, sh_gsd;

  fg_pair_t pending_fg[$];

  cpm_query_if  #(.INDEX_WIDTH(IW)) in_if();
  cpm_result_if #(.VALUE_WIDTH(VW)) out_if();
  cpm_cfg_if    #(.VALUE_WIDTH(VW)) cfg_if();

  coupled_recurrence_matrix_power_mod #(.VALUE_WIDTH(VW), .INDEX_WIDTH(IW)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // 6x6 product mod m
  function automatic mat_t mat_prod(mat_t x, mat_t y, longint unsigned m);
    mat_t r;
    longint unsigned s;
    for (int i = 0; i < cpm_pkg::DIM; i++) begin
      for (int j = 0; j < cpm_pkg::DIM; j++) begin
        s = 0;
        for (int k = 0; k < cpm_pkg::DIM; k++)
          s = (s + (x[i*cpm_pkg::DIM+k] * y[k*cpm_pkg::DIM+j]) % m) % m;
        r[i*cpm_pkg::DIM+j] = s;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned fld(logic [3*VW-1:0] r, int k);
    return longint'(r[k*VW +: VW]);
  endfunction

  // f(n), g(n) mod m from the shadow registers
  function automatic fg_pair_t recurrence_at(logic [IW-1:0] n);
    fg_pair_t res;
    mat_t base, acc;
    longint unsigned m, e, fv, gv;
    longint unsigned vec[cpm_pkg::DIM];
    m = (sh_mod == 0) ? 1 : longint'(sh_mod);
    if (n <= cpm_pkg::SEED_COUNT) begin
      res.f = VW'(fld(sh_fsd, int'(n)) % m);
      res.g = VW'(fld(sh_gsd, int'(n)) % m);
      return res;
    end
    foreach (base[i]) begin
      base[i] = 0;
      acc[i] = 0;
    end
    base[0*cpm_pkg::DIM+0] = fld(sh_fco, 0) % m;
    base[0*cpm_pkg::DIM+1] = fld(sh_fco, 1) % m;
    base[0*cpm_pkg::DIM+5] = fld(sh_fco, 2) % m;
    base[1*cpm_pkg::DIM+0] = 1 % m;
    base[2*cpm_pkg::DIM+1] = 1 % m;
    base[3*cpm_pkg::DIM+3] = fld(sh_gco, 0) % m;
    base[3*cpm_pkg::DIM+4] = fld(sh_gco, 1) % m;
    base[3*cpm_pkg::DIM+2] = fld(sh_gco, 2) % m;
    base[4*cpm_pkg::DIM+3] = 1 % m;
    base[5*cpm_pkg::DIM+4] = 1 % m;
    for (int i = 0; i < cpm_pkg::DIM; i++) acc[i*cpm_pkg::DIM+i] = 1 % m;
    e = longint'(n) - cpm_pkg::SEED_COUNT;
    while (e != 0) begin
      if (e[0]) acc = mat_prod(acc, base, m);
      e = e >> 1;
      if (e != 0) base = mat_prod(base, base, m);
    end
    vec[0] = fld(sh_fsd, 2) % m;
    vec[1] = fld(sh_fsd, 1) % m;
    vec[2] = fld(sh_fsd, 0) % m;
    vec[3] = fld(sh_gsd, 2) % m;
    vec[4] = fld(sh_gsd, 1) % m;
    vec[5] = fld(sh_gsd, 0) % m;
    fv = 0;
    gv = 0;
    for (int i = 0; i < cpm_pkg::DIM; i++) begin
      fv = (fv + (acc[0*cpm_pkg::DIM+i] * vec[i]) % m) % m;
      gv = (gv + (acc[3*cpm_pkg::DIM+i] * vec[i]) % m) % m;
    end
    res.f = VW'(fv);
    res.g = VW'(gv);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // result sink: random stalls, checks every beat against the oldest expectation
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    fg_pair_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_fg.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat f=%0d g=%0d",
                                    out_if.f_value, out_if.g_value);
        end else begin
          want = pending_fg.pop_front();
          if (out_if.f_value !== want.f || out_if.g_value !== want.g) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: f exp %0d got %0d, g exp %0d got %0d",
                       want.f, out_if.f_value, want.g, out_if.g_value);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  task automatic cfg_write(logic [cpm_pkg::CFG_IDX_W-1:0] idx, logic [3*VW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      cpm_pkg::REG_MODULUS:  sh_mod = data[VW-1:0];
      cpm_pkg::REG_F_COEFFS: sh_fco = data;
      cpm_pkg::REG_G_COEFFS: sh_gco = data;
      cpm_pkg::REG_F_SEEDS:  sh_fsd = data;
      cpm_pkg::REG_G_SEEDS:  sh_gsd = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_apply(cfg_set_t s);
    cfg_write(cpm_pkg::REG_MODULUS, (3*VW)'(s.m));
    cfg_write(cpm_pkg::REG_F_COEFFS, s.fc);
    cfg_write(cpm_pkg::REG_G_COEFFS, s.gc);
    cfg_write(cpm_pkg::REG_F_SEEDS, s.fs);
    cfg_write(cpm_pkg::REG_G_SEEDS, s.gs);
  endtask

  // hold off until the block is idle
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_fg.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_query(logic [IW-1:0] n, bit typed, fg_pair_t given);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.query_index <= n;
    do @(posedge clk); while (!in_if.ready);
    pending_fg.push_back(typed ? given : recurrence_at(n));
  endtask

  function automatic logic [VW-1:0] rand_mod();
    case ($urandom_range(0, 5))
      0: return VW'(1);
      1: return '1;
      2: return '0;
      3: return VW'($urandom_range(2, 20));
      default: return VW'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [3*VW-1:0] rand_packed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return (3*VW)'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [IW-1:0] rand_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return IW'($urandom_range(0, 2));
    if (r < 84) return IW'($urandom_range(3, 12));
    if (r < 98) return IW'($urandom_range(13, 255));
    return IW'($urandom);
  endfunction

  // directed settings: reset values, extremes, zero modulus, tiny modulus
  cfg_set_t dir_cfg [4] = '{
    '{16'd1, 48'd0, 48'd0, 48'd0, 48'd0},
    '{16'hFFFF, '1, '1, {16'hFFFF, 16'd7, 16'd1234}, {16'd3, 16'hFFFE, 16'd0}},
    '{16'd0, 48'h0005_0003_0002, 48'h0001_0004_0009, 48'h0011_0022_0033,
      48'h0044_0055_0066},
    '{16'd2, 48'h0001_0001_0001, 48'h0000_0001_0001, 48'h0001_0000_0001,
      48'h0000_0001_0000}
  };

  query_row_t dir_rows [] = '{
    '{0, 31'd0,          1, 16'd0,     16'd0},
    '{0, 31'h7FFF_FFFF,  1, 16'd0,     16'd0},
    '{0, 31'd3,          1, 16'd0,     16'd0},
    '{1, 31'd0,          1, 16'd1234,  16'd0},
    '{1, 31'd1,          1, 16'd7,     16'hFFFE},
    '{1, 31'd2,          1, 16'd0,     16'd3},
    '{1, 31'd3,          0, 16'd0,     16'd0},
    '{1, 31'd4,          0, 16'd0,     16'd0},
    '{1, 31'd5,          0, 16'd0,     16'd0},
    '{1, 31'd6,          0, 16'd0,     16'd0},
    '{1, 31'd7,          0, 16'd0,     16'd0},
    '{1, 31'd1024,       0, 16'd0,     16'd0},
    '{1, 31'h4000_0000,  0, 16'd0,     16'd0},
    '{1, 31'h7FFF_FFFF,  0, 16'd0,     16'd0},
    '{2, 31'd1,          1, 16'd0,     16'd0},
    '{2, 31'd5,          1, 16'd0,     16'd0},
    '{2, 31'd100,        1, 16'd0,     16'd0},
    '{3, 31'd2,          1, 16'd1,     16'd0},
    '{3, 31'd9,          0, 16'd0,     16'd0},
    '{3, 31'd37,         0, 16'd0,     16'd0}
  };

  initial begin
    fg_pair_t given;
    cfg_set_t s;
    int unsigned cur;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.query_index <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= cpm_pkg::REG_MODULUS;
    cfg_if.data <= '0;
    sh_mod = 1;
    sh_fco = '0;
    sh_gco = '0;
    sh_fsd = '0;
    sh_gsd = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset setting first
    cur = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur) begin
        drain();
        cur = dir_rows[i].setting;
        cfg_apply(dir_cfg[cur]);
        // unused index must leave the registers alone
        if (cur == 3) cfg_write(REG_UNUSED_LO, '1);
      end
      given.f = dir_rows[i].f;
      given.g = dir_rows[i].g;
      send_query(dir_rows[i].n, dir_rows[i].typed, given);
    end

    // random phases, each behind a full drain
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      no_idle = (p % 4 == 1);
      s.m  = rand_mod();
      s.fc = rand_packed();
      s.gc = rand_packed();
      s.fs = rand_packed();
      s.gs = rand_packed();
      cfg_apply(s);
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_UNUSED_LO + cpm_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                  (3*VW)'({$urandom, $urandom}));
      for (int k = 0; k < PHASE_ITEMS; k++) send_query(rand_index(), 0, given);
    end

    drain();
    if (errors == 0 && pending_fg.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
